/* sv/bac_pkg.sv */
// bac_pkg: shared field widths, codes and cell control types of the bump allocator
// used by bac_cell, bac_fold and bump_allocator_chunk_tables_top; no dependencies
package bac_pkg;

   // fixed widths of the request and response fields
   localparam int ADDR_W   = 16;
   localparam int SIZE_W   = 17;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 3;

   // request kinds
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NULL      = 3'd1,
      ST_HEAP_FULL = 3'd2,
      ST_LIVE_FULL = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_DEAD_FULL = 3'd5
   } status_type;

   // what a table cell does at the next edge
   typedef enum logic [1:0] {
      CELL_HOLD      = 2'd0,
      CELL_LOAD      = 2'd1,
      CELL_FROM_PREV = 2'd2,
      CELL_FROM_NEXT = 2'd3
   } cell_op_type;

   // compare results of one cell against the search key
   typedef struct packed {
      logic hit;    // entry valid and start equals key
      logic above;  // entry valid and start greater than key
   } cell_flags_type;

endpackage

/* sv/bac_cell.sv */
// bac_cell: one entry of a sorted chunk table (start, size) with its key compare
// neighbours feed it on insert and delete shifts; depends on bac_pkg
module bac_cell #(
   parameter int START_W = 16
) (
   input  logic                          clock,
   input  logic                          valid,
   input  logic                          flag_en,
   input  logic [START_W-1:0]            match_key,
   input  bac_pkg::cell_op_type          op,
   input  logic [START_W-1:0]            load_start,
   input  logic [bac_pkg::SIZE_W-1:0]    load_size,
   input  logic [START_W-1:0]            prev_start,
   input  logic [bac_pkg::SIZE_W-1:0]    prev_size,
   input  logic [START_W-1:0]            next_start,
   input  logic [bac_pkg::SIZE_W-1:0]    next_size,
   output logic [START_W-1:0]            start,
   output logic [bac_pkg::SIZE_W-1:0]    size,
   output bac_pkg::cell_flags_type       flags
);

   logic [START_W-1:0]         start_ff, start_in;
   logic [bac_pkg::SIZE_W-1:0] size_ff, size_in;
   bac_pkg::cell_flags_type    flags_ff, flags_in;

   // entry contents after the shift or load
   always_comb begin
      unique case (op)
         bac_pkg::CELL_HOLD: begin
            start_in = start_ff;
            size_in  = size_ff;
         end
         bac_pkg::CELL_LOAD: begin
            start_in = load_start;
            size_in  = load_size;
         end
         bac_pkg::CELL_FROM_PREV: begin
            start_in = prev_start;
            size_in  = prev_size;
         end
         bac_pkg::CELL_FROM_NEXT: begin
            start_in = next_start;
            size_in  = next_size;
         end
         default: begin
            start_in = start_ff;
            size_in  = size_ff;
         end
      endcase
   end

   // local compare against the key
   always_comb begin
      flags_in.hit   = valid && (start_ff == match_key);
      flags_in.above = valid && (start_ff > match_key);
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      size_ff  <= size_in;
      if (flag_en) begin
         flags_ff <= flags_in;
      end
   end

   assign start = start_ff;
   assign size  = size_ff;
   assign flags = flags_ff;

endmodule

/* sv/bac_fold.sv */
// bac_fold: two-level registered or-tree that picks the size of the one hit cell
// groups of cells are folded first, then the group results; depends on bac_pkg
module bac_fold #(
   parameter int N = 1024,
   parameter int G = 32
) (
   input  logic                                 clock,
   input  logic [N-1:0]                         hit,
   input  logic [N-1:0][bac_pkg::SIZE_W-1:0]    data,
   output logic                                 found,
   output logic [bac_pkg::SIZE_W-1:0]           found_size
);

   localparam int NG = (N + G - 1) / G;

   logic [NG*G-1:0]                      hit_pad;
   logic [NG*G-1:0][bac_pkg::SIZE_W-1:0] leaf_pad;
   logic [NG-1:0]                        grp_hit_ff, grp_hit_in;
   logic [NG-1:0][bac_pkg::SIZE_W-1:0]   grp_data_ff, grp_data_in;
   logic                                 found_ff, found_in;
   logic [bac_pkg::SIZE_W-1:0]           size_ff, size_in;

   // leaves masked by their hit bit, padded to whole groups
   for (genvar i = 0; i < NG*G; i++) begin : g_leaf
      if (i < N) begin : g_real
         assign hit_pad[i]  = hit[i];
         assign leaf_pad[i] = hit[i] ? data[i] : '0;
      end else begin : g_pad
         assign hit_pad[i]  = 1'b0;
         assign leaf_pad[i] = '0;
      end
   end

   // first level: one or per group
   for (genvar g = 0; g < NG; g++) begin : g_group
      always_comb begin
         grp_hit_in[g]  = 1'b0;
         grp_data_in[g] = '0;
         for (int k = 0; k < G; k++) begin
            grp_hit_in[g]  = grp_hit_in[g] | hit_pad[g*G + k];
            grp_data_in[g] = grp_data_in[g] | leaf_pad[g*G + k];
         end
      end
   end

   // second level: or over the groups
   always_comb begin
      found_in = 1'b0;
      size_in  = '0;
      for (int g = 0; g < NG; g++) begin
         found_in = found_in | grp_hit_ff[g];
         size_in  = size_in | grp_data_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      grp_hit_ff  <= grp_hit_in;
      grp_data_ff <= grp_data_in;
      found_ff    <= found_in;
      size_ff     <= size_in;
   end

   assign found      = found_ff;
   assign found_size = size_ff;

endmodule

/* sv/bump_allocator_chunk_tables_top.sv */
// Bump allocator with a live and a freed chunk table, each a row of bac_cell entries
// kept sorted by start. An allocate takes bytes from the bump pointer and appends to
// the live table; a free finds its start in every live cell at once, shifts the live
// row down over it and inserts the chunk into the freed row. Freed space is never
// reused. One request is in flight at a time: after the request transfer the block
// runs cell compare, group fold, final fold and table update in order; the update waits
// while an earlier response is still held, and the next request is taken after it.
// The pace is set by the compare and the two-level registered fold over the live
// cells. Table contents are not cleared at reset; only counts, bump pointer and control
// state are, so no clearing pass is needed. Depends on bac_pkg, bac_cell, bac_fold.
module bump_allocator_chunk_tables_top #(
   parameter int HEAP_BYTES  = 65536,
   parameter int CHUNK_SLOTS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [bac_pkg::SIZE_W-1:0]        req_alloc_size,
   input  logic [bac_pkg::ADDR_W-1:0]        req_free_addr,
   input  logic                              req_free_is_null,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bac_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bac_pkg::ADDR_W-1:0]        rsp_result_addr,
   output logic [bac_pkg::SIZE_W-1:0]        rsp_chunk_bytes,
   output logic [bac_pkg::COUNT_W-1:0]       rsp_live_count,
   output logic [bac_pkg::COUNT_W-1:0]       rsp_dead_count,
   output logic [bac_pkg::SIZE_W-1:0]        rsp_bytes_used
);

   localparam int HEAP_AW = $clog2(HEAP_BYTES);
   localparam int KW      = (HEAP_AW > bac_pkg::ADDR_W) ? HEAP_AW : bac_pkg::ADDR_W;
   localparam int BW      = $clog2(HEAP_BYTES + 1);
   localparam int EW      = ((BW > bac_pkg::SIZE_W) ? BW : bac_pkg::SIZE_W) + 1;
   localparam int CW      = $clog2(CHUNK_SLOTS + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MATCH = 4'b0010,
      S_FOLD  = 4'b0100,
      S_APPLY = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      fold_wait_ff, fold_wait_in;

   // captured request
   logic                       type_ff;
   logic [bac_pkg::SIZE_W-1:0] size_ff;
   logic [bac_pkg::ADDR_W-1:0] addr_ff;
   logic                       null_ff;

   // allocator state
   logic [BW-1:0] bump_ff, bump_in;
   logic [CW-1:0] live_cnt_ff, live_cnt_in;
   logic [CW-1:0] dead_cnt_ff, dead_cnt_in;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   bac_pkg::status_type          rsp_status_ff, status;
   logic [bac_pkg::ADDR_W-1:0]   rsp_addr_ff;
   logic [bac_pkg::SIZE_W-1:0]   rsp_bytes_ff, out_bytes;
   logic [bac_pkg::COUNT_W-1:0]  rsp_live_ff, rsp_dead_ff;
   logic [bac_pkg::SIZE_W-1:0]   rsp_used_ff;
   logic [KW-1:0]                out_addr;

   // table rows
   logic [CHUNK_SLOTS-1:0][KW-1:0]              live_start, dead_start;
   logic [CHUNK_SLOTS-1:0][bac_pkg::SIZE_W-1:0] live_size, dead_size;
   bac_pkg::cell_flags_type [CHUNK_SLOTS-1:0]   live_flags, dead_flags;
   logic [CHUNK_SLOTS-1:0]                      live_hit, dead_valid;

   logic                       found;
   logic [bac_pkg::SIZE_W-1:0] found_size;
   logic [KW-1:0]              key;
   logic [EW-1:0]              bump_sum;
   logic                       accept, apply_en, flag_en, live_append, free_ok;

   assign accept   = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign apply_en = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_ready);
   assign flag_en  = (state_ff == S_MATCH);
   assign key      = KW'(addr_ff);
   assign bump_sum = EW'(bump_ff) + EW'(size_ff);

   // sequencer: compare, group fold, final fold, then update
   always_comb begin
      state_in     = state_ff;
      fold_wait_in = fold_wait_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            state_in     = S_FOLD;
            fold_wait_in = 1'b1;
         end
         S_FOLD: begin
            fold_wait_in = 1'b0;
            if (!fold_wait_ff) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (apply_en) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outcome of the request
   always_comb begin
      status      = bac_pkg::ST_OK;
      out_addr    = '0;
      out_bytes   = '0;
      live_append = 1'b0;
      free_ok     = 1'b0;
      if (type_ff == bac_pkg::REQ_ALLOC) begin
         priority if (size_ff == '0) begin
            status = bac_pkg::ST_NULL;
         end else if (bump_sum > EW'(HEAP_BYTES)) begin
            status = bac_pkg::ST_HEAP_FULL;
         end else if (live_cnt_ff == CW'(CHUNK_SLOTS)) begin
            status = bac_pkg::ST_LIVE_FULL;
         end else begin
            live_append = 1'b1;
            out_addr    = KW'(bump_ff);
            out_bytes   = size_ff;
         end
      end else begin
         priority if (null_ff) begin
            status = bac_pkg::ST_NULL;
         end else if (!found) begin
            status = bac_pkg::ST_NOT_FOUND;
         end else if (dead_cnt_ff == CW'(CHUNK_SLOTS)) begin
            status    = bac_pkg::ST_DEAD_FULL;
            out_addr  = key;
            out_bytes = found_size;
         end else begin
            free_ok   = 1'b1;
            out_addr  = key;
            out_bytes = found_size;
         end
      end
   end

   // next bump pointer and counts
   always_comb begin
      bump_in     = bump_ff;
      live_cnt_in = live_cnt_ff;
      dead_cnt_in = dead_cnt_ff;
      if (apply_en && live_append) begin
         bump_in     = BW'(bump_sum);
         live_cnt_in = live_cnt_ff + CW'(1);
      end
      if (apply_en && free_ok) begin
         live_cnt_in = live_cnt_ff - CW'(1);
         dead_cnt_in = dead_cnt_ff + CW'(1);
      end
   end

   // response register: frees the cells while the result waits
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (apply_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fold_wait_ff <= 1'b0;
         bump_ff      <= '0;
         live_cnt_ff  <= '0;
         dead_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fold_wait_ff <= fold_wait_in;
         bump_ff      <= bump_in;
         live_cnt_ff  <= live_cnt_in;
         dead_cnt_ff  <= dead_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff <= req_type;
         size_ff <= req_alloc_size;
         addr_ff <= req_free_addr;
         null_ff <= req_free_is_null;
      end
      if (apply_en) begin
         rsp_status_ff <= status;
         rsp_addr_ff   <= bac_pkg::ADDR_W'(out_addr);
         rsp_bytes_ff  <= out_bytes;
         rsp_live_ff   <= bac_pkg::COUNT_W'(live_cnt_in);
         rsp_dead_ff   <= bac_pkg::COUNT_W'(dead_cnt_in);
         rsp_used_ff   <= bac_pkg::SIZE_W'(bump_in);
      end
   end

   // live table row: append at the tail, close the gap on a free
   for (genvar i = 0; i < CHUNK_SLOTS; i++) begin : g_live
      localparam logic [CW-1:0] IDX = CW'(i);
      logic                       valid;
      bac_pkg::cell_op_type       op;
      logic [KW-1:0]              nb_start;
      logic [bac_pkg::SIZE_W-1:0] nb_size;

      if (i + 1 < CHUNK_SLOTS) begin : g_next
         assign nb_start = live_start[i+1];
         assign nb_size  = live_size[i+1];
      end else begin : g_last
         assign nb_start = live_start[i];
         assign nb_size  = live_size[i];
      end

      always_comb begin
         valid = (IDX < live_cnt_ff);
         priority if (apply_en && live_append && (IDX == live_cnt_ff)) begin
            op = bac_pkg::CELL_LOAD;
         end else if (apply_en && free_ok && (live_flags[i].hit || live_flags[i].above)) begin
            op = bac_pkg::CELL_FROM_NEXT;
         end else begin
            op = bac_pkg::CELL_HOLD;
         end
      end

      assign live_hit[i] = live_flags[i].hit;

      bac_cell #(.START_W(KW)) u_cell (
         .clock      (clock),
         .valid      (valid),
         .flag_en    (flag_en),
         .match_key  (key),
         .op         (op),
         .load_start (KW'(bump_ff)),
         .load_size  (size_ff),
         .prev_start (live_start[i]),
         .prev_size  (live_size[i]),
         .next_start (nb_start),
         .next_size  (nb_size),
         .start      (live_start[i]),
         .size       (live_size[i]),
         .flags      (live_flags[i])
      );
   end

   // freed table row: sorted insert, entries above the new start move up
   for (genvar i = 0; i < CHUNK_SLOTS; i++) begin : g_dead
      localparam logic [CW-1:0] IDX = CW'(i);
      bac_pkg::cell_op_type       op;
      logic                       lower_kept;
      logic [KW-1:0]              pv_start;
      logic [bac_pkg::SIZE_W-1:0] pv_size;

      assign dead_valid[i] = (IDX < dead_cnt_ff);

      if (i == 0) begin : g_first
         assign lower_kept = 1'b1;
         assign pv_start   = dead_start[i];
         assign pv_size    = dead_size[i];
      end else begin : g_prev
         assign lower_kept = dead_valid[i-1] && !dead_flags[i-1].above;
         assign pv_start   = dead_start[i-1];
         assign pv_size    = dead_size[i-1];
      end

      always_comb begin
         priority if (!(apply_en && free_ok)) begin
            op = bac_pkg::CELL_HOLD;
         end else if (dead_valid[i] && !dead_flags[i].above) begin
            op = bac_pkg::CELL_HOLD;
         end else if (lower_kept) begin
            op = bac_pkg::CELL_LOAD;
         end else begin
            op = bac_pkg::CELL_FROM_PREV;
         end
      end

      bac_cell #(.START_W(KW)) u_cell (
         .clock      (clock),
         .valid      (dead_valid[i]),
         .flag_en    (flag_en),
         .match_key  (key),
         .op         (op),
         .load_start (key),
         .load_size  (found_size),
         .prev_start (pv_start),
         .prev_size  (pv_size),
         .next_start (dead_start[i]),
         .next_size  (dead_size[i]),
         .start      (dead_start[i]),
         .size       (dead_size[i]),
         .flags      (dead_flags[i])
      );
   end

   // pick the size of the matching live entry
   bac_fold #(.N(CHUNK_SLOTS), .G(32)) u_fold (
      .clock      (clock),
      .hit        (live_hit),
      .data       (live_size),
      .found      (found),
      .found_size (found_size)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_addr = rsp_addr_ff;
   assign rsp_chunk_bytes = rsp_bytes_ff;
   assign rsp_live_count  = rsp_live_ff;
   assign rsp_dead_count  = rsp_dead_ff;
   assign rsp_bytes_used  = rsp_used_ff;

endmodule
